[sv/spf_pkg.sv]
package spf_pkg;

  localparam int QW        = 16;     // query / prime field width
  localparam int EW        = 5;      // exponent width
  localparam int CW        = 13;     // divisor count width
  localparam int FIELD_MAX = 65535;  // widest value a 16-bit field carries
  localparam int MAX_N_DEF = 65535;

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  // register index decoded from paddr[CFG_AW-1]
  localparam logic LIMIT_IDX = 1'b0;

  typedef struct packed {
    logic [QW-1:0] prime;
    logic [EW-1:0] exponent;
    logic [CW-1:0] divisor_count;
    logic          out_of_range;
    logic          last;
  } out_item_t;

  // largest value the table can cover for a given MAX_N
  function automatic int eff_max(input int n);
    return (n > FIELD_MAX) ? FIELD_MAX : n;
  endfunction

  // floor(sqrt(n)), elaboration only
  function automatic int isqrt(input int n);
    int r = 0;
    while ((r + 1) * (r + 1) <= n) r++;
    return r;
  endfunction

endpackage

[sv/spf_ifs.sv]
interface spf_in_if import spf_pkg::*; ();
  logic          valid;
  logic          ready;
  logic [QW-1:0] query_value;

  modport source (output valid, output query_value, input ready);
  modport sink   (input valid, input query_value, output ready);
endinterface

interface spf_out_if import spf_pkg::*; ();
  logic          valid;
  logic          ready;
  logic [QW-1:0] prime;
  logic [EW-1:0] exponent;
  logic [CW-1:0] divisor_count;
  logic          out_of_range;
  logic          last;

  modport source (output valid, output prime, output exponent, output divisor_count,
                  output out_of_range, output last, input ready);
  modport sink   (input valid, input prime, input exponent, input divisor_count,
                  input out_of_range, input last, output ready);
endinterface

[sv/spf_cfg.sv]
module spf_cfg import spf_pkg::*; #(
  parameter int MAX_N = MAX_N_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic [$clog2(eff_max(MAX_N)+1)-1:0] limit_o,
  output logic              wr_fire_o
);

  localparam int EFF_MAX = eff_max(MAX_N);
  localparam int AW      = $clog2(EFF_MAX + 1);

  logic          sel_lim;
  logic [QW-1:0] wv;
  logic [QW-1:0] raw_r, raw_nxt;
  logic [AW-1:0] lim_r, lim_nxt, lim_sat;

  assign sel_lim   = (paddr[CFG_AW-1] == LIMIT_IDX);
  assign wr_fire_o = psel && penable && pwrite && sel_lim;
  assign wv        = pwdata[QW-1:0];

  // clamp to [2, EFF_MAX]
  always_comb begin
    priority if (wv < QW'(2)) begin
      lim_sat = AW'(2);
    end else if (int'(wv) > EFF_MAX) begin
      lim_sat = AW'(EFF_MAX);
    end else begin
      lim_sat = AW'(wv);
    end
  end

  always_comb begin
    raw_nxt = raw_r;
    lim_nxt = lim_r;
    if (wr_fire_o) begin
      raw_nxt = wv;
      lim_nxt = lim_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_r <= QW'(FIELD_MAX);
      lim_r <= AW'(EFF_MAX);
    end else begin
      raw_r <= raw_nxt;
      lim_r <= lim_nxt;
    end
  end

  assign limit_o = lim_r;
  assign prdata  = sel_lim ? CFG_DW'(raw_r) : '0;

endmodule

[sv/spf_mem.sv]
module spf_mem import spf_pkg::*; #(
  parameter int MAX_N = MAX_N_DEF
) (
  input  logic                                 clk,
  input  logic                                 we_i,
  input  logic [$clog2(eff_max(MAX_N)+1)-1:0]  waddr_i,
  input  logic [$clog2(eff_max(MAX_N)+1)-1:0]  wspf_i,
  input  logic [$clog2(eff_max(MAX_N)+1)-1:0]  wquo_i,
  input  logic [$clog2(eff_max(MAX_N)+1)-1:0]  raddr_i,
  output logic [$clog2(eff_max(MAX_N)+1)-1:0]  rspf_o,
  output logic [$clog2(eff_max(MAX_N)+1)-1:0]  rquo_o
);

  localparam int EFF_MAX = eff_max(MAX_N);
  localparam int AW      = $clog2(EFF_MAX + 1);
  localparam int DEPTH   = EFF_MAX + 1;

  // smallest prime factor and cofactor n / spf(n), one row per value
  logic [AW-1:0] spf_ram [DEPTH];
  logic [AW-1:0] quo_ram [DEPTH];
  logic [AW-1:0] rspf_r, rquo_r;

  always_ff @(posedge clk) begin
    if (we_i) begin
      spf_ram[waddr_i] <= wspf_i;
      quo_ram[waddr_i] <= wquo_i;
    end
    rspf_r <= spf_ram[raddr_i];
    rquo_r <= quo_ram[raddr_i];
  end

  assign rspf_o = rspf_r;
  assign rquo_o = rquo_r;

endmodule

[sv/spf_sieve.sv]
module spf_sieve import spf_pkg::*; #(
  parameter int MAX_N = MAX_N_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start_i,
  input  logic [$clog2(eff_max(MAX_N)+1)-1:0]  limit_i,
  output logic                                 busy_o,
  output logic                                 we_o,
  output logic [$clog2(eff_max(MAX_N)+1)-1:0]  waddr_o,
  output logic [$clog2(eff_max(MAX_N)+1)-1:0]  wspf_o,
  output logic [$clog2(eff_max(MAX_N)+1)-1:0]  wquo_o
);

  localparam int EFF_MAX = eff_max(MAX_N);
  localparam int AW      = $clog2(EFF_MAX + 1);
  localparam int MW      = AW + 1;
  localparam int ISQ     = isqrt(EFF_MAX);
  localparam int IW      = $clog2(ISQ + 1);

  typedef enum logic [3:0] {
    S_INIT = 4'b0001,
    S_SET  = 4'b0010,
    S_RUN  = 4'b0100,
    S_DONE = 4'b1000
  } sv_state_t;

  sv_state_t     state_r, state_nxt;
  logic [MW-1:0] m_r, m_nxt;      // address (init) / current multiple (sweep)
  logic [IW-1:0] i_r, i_nxt;      // sweep factor, descending
  logic [AW-1:0] k_r, k_nxt;      // m_r / i_r
  logic [MW-1:0] lim_ext;

  assign lim_ext = MW'(limit_i);

  // Init writes spf[n]=n, quo[n]=1. Sweep runs i downward and writes i over
  // every multiple from i*i, so the last (smallest) factor wins.
  always_comb begin
    state_nxt = state_r;
    m_nxt     = m_r;
    i_nxt     = i_r;
    k_nxt     = k_r;
    we_o      = 1'b0;
    waddr_o   = m_r[AW-1:0];
    wspf_o    = AW'(i_r);
    wquo_o    = k_r;
    unique case (state_r)
      S_INIT: begin
        if (m_r > lim_ext) begin
          state_nxt = S_SET;
        end else begin
          we_o   = 1'b1;
          wspf_o = m_r[AW-1:0];
          wquo_o = AW'(1);
          m_nxt  = m_r + MW'(1);
        end
      end
      S_SET: begin
        m_nxt     = MW'(i_r) * MW'(i_r);
        k_nxt     = AW'(i_r);
        state_nxt = S_RUN;
      end
      S_RUN: begin
        if (m_r > lim_ext) begin
          if (i_r == IW'(2)) begin
            state_nxt = S_DONE;
          end else begin
            i_nxt     = i_r - IW'(1);
            state_nxt = S_SET;
          end
        end else begin
          we_o  = 1'b1;
          m_nxt = m_r + MW'(i_r);
          k_nxt = k_r + AW'(1);
        end
      end
      S_DONE: begin
      end
      default: state_nxt = S_DONE;
    endcase
    if (start_i) begin
      state_nxt = S_INIT;
      m_nxt     = '0;
      i_nxt     = IW'(ISQ);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      m_r     <= '0;
      i_r     <= IW'(ISQ);
    end else begin
      state_r <= state_nxt;
      m_r     <= m_nxt;
      i_r     <= i_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r <= k_nxt;
  end

  assign busy_o = (state_r != S_DONE);

  a_sweep_cofactor: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RUN && we_o) |-> (32'(k_r) * 32'(i_r) == 32'(m_r)))
    else $error("sieve cofactor does not match multiple");

  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    start_i |=> (state_r == S_INIT && m_r == '0))
    else $error("sieve did not restart on limit write");

  a_factor_floor: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RUN || state_r == S_SET) |-> (i_r >= IW'(2)))
    else $error("sieve factor dropped below two");

endmodule

[sv/spf_walk.sv]
module spf_walk import spf_pkg::*; #(
  parameter int MAX_N = MAX_N_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 busy_i,
  input  logic [$clog2(eff_max(MAX_N)+1)-1:0]  limit_i,
  spf_in_if.sink                               in_ch,
  spf_out_if.source                            out_ch,
  output logic [$clog2(eff_max(MAX_N)+1)-1:0]  raddr_o,
  input  logic [$clog2(eff_max(MAX_N)+1)-1:0]  rspf_i,
  input  logic [$clog2(eff_max(MAX_N)+1)-1:0]  rquo_i
);

  localparam int EFF_MAX = eff_max(MAX_N);
  localparam int AW      = $clog2(EFF_MAX + 1);
  localparam int PRW     = CW + EW;

  typedef enum logic [2:0] {
    W_IDLE = 3'b001,
    W_SPEC = 3'b010,
    W_RUN  = 3'b100
  } wk_state_t;

  wk_state_t     state_r, state_nxt;
  logic [AW-1:0] rem_r, rem_nxt;
  logic [AW-1:0] cur_p_r, cur_p_nxt;
  logic [EW-1:0] exp_r, exp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          oor_r, oor_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_item_t     out_item_r, out_item_nxt;

  logic          slot_free, acc, same, emit;
  logic [EW-1:0] exp_inc, emit_exp;
  logic [PRW-1:0] prod;
  logic [CW-1:0] cnt_new;
  logic [QW:0]   q_ext, lim_ext;
  out_item_t     item;

  assign slot_free   = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == W_IDLE) && !busy_i;
  assign acc         = in_ch.valid && in_ch.ready;

  assign q_ext    = (QW+1)'(in_ch.query_value);
  assign lim_ext  = (QW+1)'(limit_i);
  assign same     = (rspf_i == cur_p_r);
  assign exp_inc  = exp_r + EW'(1);
  assign emit_exp = same ? exp_inc : exp_r;
  assign prod     = PRW'(cnt_r) * (PRW'(emit_exp) + PRW'(1));
  assign cnt_new  = prod[CW-1:0];

  // One table read per step. A new prime first closes the previous group
  // (address held), then the next step counts it.
  always_comb begin
    state_nxt = state_r;
    rem_nxt   = rem_r;
    cur_p_nxt = cur_p_r;
    exp_nxt   = exp_r;
    cnt_nxt   = cnt_r;
    oor_nxt   = oor_r;
    emit      = 1'b0;
    item      = '0;
    raddr_o   = rem_r;
    unique case (state_r)
      W_IDLE: begin
        raddr_o = in_ch.query_value[AW-1:0];
        if (acc) begin
          priority if (q_ext > lim_ext) begin
            state_nxt = W_SPEC;
            oor_nxt   = 1'b1;
          end else if (q_ext < (QW+1)'(2)) begin
            state_nxt = W_SPEC;
            oor_nxt   = 1'b0;
          end else begin
            state_nxt = W_RUN;
            rem_nxt   = in_ch.query_value[AW-1:0];
            cur_p_nxt = '0;
            exp_nxt   = '0;
            cnt_nxt   = CW'(1);
          end
        end
      end
      W_SPEC: begin
        if (slot_free) begin
          emit               = 1'b1;
          item.divisor_count = CW'(1);
          item.out_of_range  = oor_r;
          item.last          = 1'b1;
          state_nxt          = W_IDLE;
        end
      end
      W_RUN: begin
        if (!same) begin
          if (exp_r == '0) begin
            cur_p_nxt = rspf_i;
          end else if (slot_free) begin
            emit               = 1'b1;
            item.prime         = QW'(cur_p_r);
            item.exponent      = exp_r;
            item.divisor_count = cnt_new;
            cnt_nxt            = cnt_new;
            cur_p_nxt          = rspf_i;
            exp_nxt            = '0;
          end
        end else if (rquo_i > AW'(1)) begin
          exp_nxt = exp_inc;
          rem_nxt = rquo_i;
          raddr_o = rquo_i;
        end else if (slot_free) begin
          emit               = 1'b1;
          item.prime         = QW'(cur_p_r);
          item.exponent      = exp_inc;
          item.divisor_count = cnt_new;
          item.last          = 1'b1;
          exp_nxt            = exp_inc;
          cnt_nxt            = cnt_new;
          rem_nxt            = rquo_i;
          state_nxt          = W_IDLE;
        end
      end
      default: state_nxt = W_IDLE;
    endcase
  end

  always_comb begin
    out_item_nxt = emit ? item : out_item_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= W_IDLE;
      out_valid_r <= 1'b0;
      rem_r       <= '0;
      cur_p_r     <= '0;
      exp_r       <= '0;
      cnt_r       <= CW'(1);
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      rem_r       <= rem_nxt;
      cur_p_r     <= cur_p_nxt;
      exp_r       <= exp_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    oor_r      <= oor_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.prime         = out_item_r.prime;
  assign out_ch.exponent      = out_item_r.exponent;
  assign out_ch.divisor_count = out_item_r.divisor_count;
  assign out_ch.out_of_range  = out_item_r.out_of_range;
  assign out_ch.last          = out_item_r.last;

  a_range_to_spec: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && q_ext > lim_ext) |=> (state_r == W_SPEC && oor_r))
    else $error("out-of-range query not routed to error result");

  a_zero_prime_item: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.prime == '0) |->
      (out_ch.last && out_ch.divisor_count == CW'(1) && out_ch.exponent == '0))
    else $error("prime-zero item malformed");

  a_factor_item: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.prime != '0) |->
      (out_ch.exponent != '0 && !out_ch.out_of_range && out_ch.prime >= QW'(2)))
    else $error("factor item with zero exponent or bad prime");

endmodule

[sv/smallest_factor_table_factorizer_top.sv]
// Channel   Dir  Handshake         Payload
// in_ch     in   valid/ready       query_value[15:0]
// out_ch    out  valid/ready       prime[15:0] exponent[4:0] divisor_count[12:0]
//                                  out_of_range last
// cfg_*     in   APB, pready = 1   reg 0 @ 0x0: table_limit[15:0]
//
// Walk: reads the query, then each prime factor in turn, and closes each group at a
//   new prime; 0, 1 and out-of-range values give one marker item. Each step is one
//   read of the table port. Reset: an init pass over 0..limit, then a descending
//   sweep of the factors down to 2; a limit write rebuilds the table.
//   Stalls: a full output register pauses the walk; in_ch.ready is low during a
//   build and while a query is in flight.
module smallest_factor_table_factorizer_top import spf_pkg::*; #(
  parameter int MAX_N = MAX_N_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  spf_in_if.sink            in_ch,
  spf_out_if.source         out_ch,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  localparam int EFF_MAX = eff_max(MAX_N);
  localparam int AW      = $clog2(EFF_MAX + 1);

  logic [AW-1:0] limit;         // effective limit, clamped to [2, EFF_MAX]
  logic          cfg_wr;        // limit write this cycle, restarts the build
  logic          sieve_busy;
  logic          busy;

  // sieve write port
  logic          we;
  logic [AW-1:0] waddr, wspf, wquo;

  // walk read port
  logic [AW-1:0] raddr, rspf, rquo;

  assign cfg_pready = 1'b1;

  // hold off queries in the write cycle too, the build starts in the cycle after it
  assign busy = sieve_busy || cfg_wr;

  spf_cfg #(.MAX_N(MAX_N)) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (cfg_psel),
    .penable   (cfg_penable),
    .pwrite    (cfg_pwrite),
    .paddr     (cfg_paddr),
    .pwdata    (cfg_pwdata),
    .prdata    (cfg_prdata),
    .limit_o   (limit),
    .wr_fire_o (cfg_wr)
  );

  spf_sieve #(.MAX_N(MAX_N)) u_sieve (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (cfg_wr),
    .limit_i (limit),
    .busy_o  (sieve_busy),
    .we_o    (we),
    .waddr_o (waddr),
    .wspf_o  (wspf),
    .wquo_o  (wquo)
  );

  // spf[n] and n/spf[n] side by side, so the walk never divides
  spf_mem #(.MAX_N(MAX_N)) u_mem (
    .clk     (clk),
    .we_i    (we),
    .waddr_i (waddr),
    .wspf_i  (wspf),
    .wquo_i  (wquo),
    .raddr_i (raddr),
    .rspf_o  (rspf),
    .rquo_o  (rquo)
  );

  spf_walk #(.MAX_N(MAX_N)) u_walk (
    .clk     (clk),
    .rst_n   (rst_n),
    .busy_i  (busy),
    .limit_i (limit),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .raddr_o (raddr),
    .rspf_i  (rspf),
    .rquo_i  (rquo)
  );

endmodule

[tb/sv/smallest_factor_table_factorizer_top_tb.sv]
`timescale 1ns / 100ps

module smallest_factor_table_factorizer_top_tb;
  import spf_pkg::*;

  // Limit register sits at index 0; the other index decoded by paddr[2] is unmapped.
  localparam logic [CFG_AW-1:0] LIMIT_ADDR = {LIMIT_IDX, 2'b00};
  localparam logic [CFG_AW-1:0] SPARE_ADDR = {~LIMIT_IDX, 2'b00};

  // Longest legal quiet stretch is the sieve after reset at limit 65535;
  // allow several times that.
  localparam int unsigned STALL_LIMIT = 2000000;
  // Drain margin at the end.
  localparam int DRAIN_CYCLES = 40;

  logic clk = 1'b0;
  logic rst_n;

  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  spf_in_if  in_ch ();
  spf_out_if out_ch ();

  smallest_factor_table_factorizer_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor state: our own smallest-prime-factor table and effective limit.
  // ---------------------------------------------------------------------------
  logic [QW-1:0] spf_table [0:FIELD_MAX];
  int unsigned   spf_limit;
  out_item_t     pending_factors [$];   // expected result items, oldest first

  int unsigned send_gap_pct;    // chance the sender idles on a given cycle
  int unsigned sink_stall_pct;  // chance the receiver stalls on a given cycle
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles = 0;

  // Clamp the raw register value and rerun the sieve over 2..limit.
  function automatic void rebuild_spf_table(input logic [QW-1:0] raw_limit);
    int unsigned i, m;
    spf_limit = raw_limit;
    if (spf_limit < 2) spf_limit = 2;
    if (spf_limit > MAX_N_DEF) spf_limit = MAX_N_DEF;
    if (spf_limit > FIELD_MAX) spf_limit = FIELD_MAX;
    for (i = 0; i <= FIELD_MAX; i++) spf_table[i] = '0;
    for (i = 2; i <= spf_limit; i++) begin
      if (spf_table[i] == '0) begin
        spf_table[i] = i[QW-1:0];
        for (m = i * i; m <= spf_limit; m += i) begin
          if (spf_table[m] == '0) spf_table[m] = i[QW-1:0];
        end
      end
    end
  endfunction

  // Walk the query down the table: one expected item per distinct prime, or one marker item.
  function automatic void predict_factors(input logic [QW-1:0] query);
    int unsigned rest, p, e, cnt;
    out_item_t   r;
    rest = query;
    cnt  = 1;
    r    = '0;
    if (query > spf_limit || query < 2) begin
      // trivial values and out-of-range values: single marker item
      r.divisor_count = 1;
      r.out_of_range  = (query > spf_limit);
      r.last          = 1'b1;
      pending_factors.insert(pending_factors.size(), r);
      return;
    end
    while (rest > 1) begin
      p = spf_table[rest];
      e = 0;
      while (rest > 1 && spf_table[rest] == p) begin
        rest = rest / p;
        e++;
      end
      cnt             = (cnt * (e + 1)) & 32'h1fff;
      r.prime         = p[QW-1:0];
      r.exponent      = e[EW-1:0];
      r.divisor_count = cnt[CW-1:0];
      r.out_of_range  = 1'b0;
      r.last          = (rest <= 1);
      pending_factors.insert(pending_factors.size(), r);
    end
  endfunction

  // Random query shaped to reach deep walks: mostly smooth in-range values
  // with many repeated small factors, plus limit edges, tiny values and noise.
  function automatic logic [QW-1:0] pick_query();
    int unsigned v, f, k;
    case ($urandom_range(0, 9))
      0, 1: v = $urandom_range(0, FIELD_MAX);   // noise, often out of range
      2:    v = $urandom_range(0, 3);
      3:    v = spf_limit + 1 - $urandom_range(0, 2);
      default: begin
        v = $urandom_range(1, 60);              // random cofactor
        if (v > spf_limit) v = spf_limit;
        for (k = 0; k < 16; k++) begin
          f = $urandom_range(2, 19);
          if (v * f <= spf_limit) v = v * f;
        end
      end
    endcase
    if (v > FIELD_MAX) v = FIELD_MAX;
    return v[QW-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Input side: one query item per call. valid is left high on return so that
  // back-to-back items never lower and raise it in the same step.
  // ---------------------------------------------------------------------------
  task automatic send_query(input logic [QW-1:0] query);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.query_value <= query;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_factors(query);
  endtask

  // Stop sending and wait until every predicted item has come back.
  task automatic drain_queries();
    in_ch.valid <= 1'b0;
    while (pending_factors.size() != 0) @(posedge clk);
  endtask

  // APB write: setup cycle, then access cycle; pready is sampled at the edge.
  task automatic write_reg(input logic [CFG_AW-1:0] addr, input logic [QW-1:0] value);
    logic [CFG_DW-1:0] data;
    data = {16'($urandom_range(0, 65535)), value};   // upper bits are don't-care
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (addr[CFG_AW-1] == LIMIT_IDX) rebuild_spf_table(value);
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random backpressure, compare each accepted item to the
  // oldest prediction, and a watchdog on cycles without any handshake.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : factor_check
    out_item_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_factors.size() == 0) begin
          $error("unexpected item: prime %0d exponent %0d count %0d oor %0b last %0b",
                 out_ch.prime, out_ch.exponent, out_ch.divisor_count,
                 out_ch.out_of_range, out_ch.last);
          mismatch_count++;
        end else begin
          want = pending_factors.pop_front();
          if (out_ch.prime !== want.prime) begin
            $error("prime: expected %0d, actual %0d", want.prime, out_ch.prime);
            mismatch_count++;
          end
          if (out_ch.exponent !== want.exponent) begin
            $error("exponent: expected %0d, actual %0d", want.exponent, out_ch.exponent);
            mismatch_count++;
          end
          if (out_ch.divisor_count !== want.divisor_count) begin
            $error("divisor_count: expected %0d, actual %0d",
                   want.divisor_count, out_ch.divisor_count);
            mismatch_count++;
          end
          if (out_ch.out_of_range !== want.out_of_range) begin
            $error("out_of_range: expected %0b, actual %0b",
                   want.out_of_range, out_ch.out_of_range);
            mismatch_count++;
          end
          if (out_ch.last !== want.last) begin
            $error("last: expected %0b, actual %0b", want.last, out_ch.last);
            mismatch_count++;
          end
        end
      end
      out_ch.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Full table after reset: field extremes, prime powers, many distinct primes,
  // largest prime, highest divisor count.
  task automatic test_full_table_corners();
    int unsigned corners [$] = '{0, 1, 2, 3, 4, 65535, 65534, 65521, 32768, 59049,
                                 30030, 60060, 45360, 55440, 43690, 21845, 49152};
    foreach (corners[i]) send_query(corners[i][QW-1:0]);
  endtask

  task automatic test_full_table_random(input int n);
    repeat (n) send_query(pick_query());
  endtask

  // Limits below two clamp to two; a write to the unmapped index changes nothing.
  task automatic test_limit_floor();
    drain_queries();
    write_reg(LIMIT_ADDR, 16'd0);
    send_query(16'd0);
    send_query(16'd1);
    send_query(16'd2);
    send_query(16'd3);
    send_query(16'hffff);
    drain_queries();
    write_reg(LIMIT_ADDR, 16'd1);
    send_query(16'd2);
    send_query(16'd3);
    drain_queries();
    write_reg(LIMIT_ADDR, 16'd2);
    write_reg(SPARE_ADDR, 16'd9);   // ignored: 3 must stay out of range
    send_query(16'd3);
    send_query(16'd2);
  endtask

  task automatic test_small_limits(input int n_limits, input int n_items);
    repeat (n_limits) begin
      drain_queries();
      write_reg(LIMIT_ADDR, QW'($urandom_range(3, 400)));
      repeat (n_items) send_query(pick_query());
    end
  endtask

  task automatic test_mid_limit(input int n);
    drain_queries();
    write_reg(LIMIT_ADDR, QW'($urandom_range(2000, 12000)));
    repeat (n) send_query(pick_query());
  endtask

  initial begin
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.query_value <= '0;
    cfg_psel          <= 1'b0;
    cfg_penable       <= 1'b0;
    cfg_pwrite        <= 1'b0;
    cfg_paddr         <= '0;
    cfg_pwdata        <= '0;
    rebuild_spf_table(16'hffff);   // reset limit

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // sender idles often, receiver stalls more
    send_gap_pct   = 27;
    sink_stall_pct = 47;
    test_full_table_corners();
    test_full_table_random(60);

    // roles swapped
    send_gap_pct   = 47;
    sink_stall_pct = 27;
    test_limit_floor();
    test_small_limits(3, 12);

    // no idling at all
    send_gap_pct   = 0;
    sink_stall_pct = 0;
    test_mid_limit(40);

    drain_queries();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/spf_pkg.sv
sv/spf_ifs.sv
sv/spf_cfg.sv
sv/spf_mem.sv
sv/spf_sieve.sv
sv/spf_walk.sv
sv/smallest_factor_table_factorizer_top.sv
tb/sv/smallest_factor_table_factorizer_top_tb.sv
